// File: hw/rtl/frustum_box_containment_test_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frustum box containment test
// Shared concurrent assertion forms, clocked on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef FRUSTUM_BOX_CONTAINMENT_TEST_MACROS_SVH
`define FRUSTUM_BOX_CONTAINMENT_TEST_MACROS_SVH

// The condition holds at every clock edge.
`define FBCT_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define FBCT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define FBCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/fbct_pkg.sv
// ----------------------------------------------------------------------------
// Frustum box containment test package
// Widths, counts and the types shared by the plane setup, cells and top level.
// ----------------------------------------------------------------------------
package fbct_pkg;

	localparam int ENT_W      = 32;
	localparam int REG_W      = 64;
	localparam int NUM_REGS   = 8;
	localparam int IDX_W      = 4;
	localparam int NUM_AXES   = 3;
	localparam int NUM_PLANES = 6;
	localparam int NRM_W      = ENT_W + 2;
	localparam int PROD_W     = NRM_W + ENT_W;
	localparam int SUM_W      = PROD_W + 2;

	typedef struct packed {
		logic [NUM_AXES-1:0][ENT_W-1:0] hi;
		logic [NUM_AXES-1:0][ENT_W-1:0] lo;
	} box_t;

	typedef struct packed {
		logic [NUM_AXES-1:0][NRM_W-1:0] nrm;
		logic [SUM_W-1:0]               off;
	} plane_t;

	typedef struct packed {
		logic vld;
		logic ok;
		box_t box;
	} link_t;

endpackage

// File: hw/rtl/fbct_box_if.sv
// ----------------------------------------------------------------------------
// Box request channel
// Valid/ready channel carrying the minimum and maximum corners of one box.
// ----------------------------------------------------------------------------
interface fbct_box_if;
	logic                              valid;
	logic                              ready;
	logic signed [fbct_pkg::ENT_W-1:0] box_min_x;
	logic signed [fbct_pkg::ENT_W-1:0] box_min_y;
	logic signed [fbct_pkg::ENT_W-1:0] box_min_z;
	logic signed [fbct_pkg::ENT_W-1:0] box_max_x;
	logic signed [fbct_pkg::ENT_W-1:0] box_max_y;
	logic signed [fbct_pkg::ENT_W-1:0] box_max_z;

	modport source (
		output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		input  ready
	);

	modport sink (
		input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
		output ready
	);
endinterface

// File: hw/rtl/fbct_res_if.sv
// ----------------------------------------------------------------------------
// Containment result channel
// Valid/ready channel carrying the inside flag of one box.
// ----------------------------------------------------------------------------
interface fbct_res_if;
	logic valid;
	logic ready;
	logic box_inside;

	modport source (
		output valid, box_inside,
		input  ready
	);

	modport sink (
		input  valid, box_inside,
		output ready
	);
endinterface

// File: hw/rtl/fbct_planes.sv
// ----------------------------------------------------------------------------
// Clip plane setup
// Forms the six negated clip planes from the matrix registers and holds them.
// ----------------------------------------------------------------------------
module fbct_planes #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                               clk,
	input  logic                                               arst_n,
	input  logic [fbct_pkg::NUM_REGS-1:0][fbct_pkg::REG_W-1:0] mat,
	output fbct_pkg::plane_t [fbct_pkg::NUM_PLANES-1:0]        pln
);

	localparam logic signed [fbct_pkg::SUM_W-1:0] BIAS =
		fbct_pkg::SUM_W'(3) << FRAC_BITS;
	localparam logic signed [fbct_pkg::SUM_W-1:0] OFF_RST = (-BIAS) <<< FRAC_BITS;
	localparam fbct_pkg::plane_t PLN_RST = '{nrm: '0, off: OFF_RST};

	logic signed [fbct_pkg::NRM_W-1:0] row_sum [fbct_pkg::NUM_PLANES][fbct_pkg::NUM_AXES+1];
	fbct_pkg::plane_t [fbct_pkg::NUM_PLANES-1:0] pln_d;
	fbct_pkg::plane_t [fbct_pkg::NUM_PLANES-1:0] pln_q;

	for (genvar p = 0; p < fbct_pkg::NUM_PLANES; p++) begin : g_plane
		localparam int  ROW = p / 2;
		localparam bit  NEG = (p % 2) == 1;
		for (genvar a = 0; a <= fbct_pkg::NUM_AXES; a++) begin : g_col
			localparam int WI  = 2 * a + 1;
			localparam int RI  = 2 * a + ROW / 2;
			localparam int RLO = (ROW % 2) * fbct_pkg::ENT_W;
			logic signed [fbct_pkg::ENT_W-1:0] w_e;
			logic signed [fbct_pkg::ENT_W-1:0] r_e;
			assign w_e = mat[WI][2*fbct_pkg::ENT_W-1:fbct_pkg::ENT_W];
			assign r_e = mat[RI][RLO +: fbct_pkg::ENT_W];
			assign row_sum[p][a] = NEG ?
				fbct_pkg::NRM_W'(w_e) - fbct_pkg::NRM_W'(r_e) :
				fbct_pkg::NRM_W'(w_e) + fbct_pkg::NRM_W'(r_e);
		end
		for (genvar a = 0; a < fbct_pkg::NUM_AXES; a++) begin : g_nrm
			assign pln_d[p].nrm[a] = -row_sum[p][a];
		end
		assign pln_d[p].off =
			(-fbct_pkg::SUM_W'(row_sum[p][fbct_pkg::NUM_AXES]) - BIAS) <<< FRAC_BITS;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pln_q <= {fbct_pkg::NUM_PLANES{PLN_RST}};
		end else begin
			pln_q <= pln_d;
		end
	end

	assign pln = pln_q;

endmodule

// File: hw/rtl/fbct_cell.sv
// ----------------------------------------------------------------------------
// Plane test cell
// Two-stage cell: picks the far corner and forms three products, then sums
// them with the plane offset and clears the inside flag on a rejection.
// ----------------------------------------------------------------------------
`include "frustum_box_containment_test_macros.svh"

module fbct_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  fbct_pkg::plane_t pln,
	input  fbct_pkg::link_t  up,
	output logic             up_rdy,
	output fbct_pkg::link_t  dn,
	input  logic             dn_rdy
);

	logic signed [fbct_pkg::NRM_W-1:0]  nrm_s [fbct_pkg::NUM_AXES];
	logic signed [fbct_pkg::PROD_W-1:0] opa   [fbct_pkg::NUM_AXES];
	logic signed [fbct_pkg::PROD_W-1:0] opb   [fbct_pkg::NUM_AXES];
	logic signed [fbct_pkg::PROD_W-1:0] prod  [fbct_pkg::NUM_AXES];
	logic signed [fbct_pkg::PROD_W-1:0] prod_s1 [fbct_pkg::NUM_AXES];
	logic signed [fbct_pkg::SUM_W-1:0]  sum;
	logic                               reject;
	logic                               en_s1;
	logic                               en_s2;
	logic                               v_s1;
	logic                               v_s2;
	logic                               ok_s1;
	logic                               ok_s2;
	fbct_pkg::box_t                     box_s1;
	fbct_pkg::box_t                     box_s2;

	assign en_s2  = !v_s2 || dn_rdy;
	assign en_s1  = !v_s1 || en_s2;
	assign up_rdy = en_s1;

	always_comb begin
		for (int a = 0; a < fbct_pkg::NUM_AXES; a++) begin
			nrm_s[a] = pln.nrm[a];
			opa[a]   = fbct_pkg::PROD_W'(nrm_s[a]);
			if (!nrm_s[a][fbct_pkg::NRM_W-1] && (nrm_s[a] != '0)) begin
				opb[a] = fbct_pkg::PROD_W'($signed(up.box.hi[a]));
			end else begin
				opb[a] = fbct_pkg::PROD_W'($signed(up.box.lo[a]));
			end
			prod[a] = opa[a] * opb[a];
		end
	end

	assign sum = fbct_pkg::SUM_W'(prod_s1[0]) + fbct_pkg::SUM_W'(prod_s1[1]) +
		fbct_pkg::SUM_W'(prod_s1[2]) + $signed(pln.off);
	assign reject = !sum[fbct_pkg::SUM_W-1] && (sum != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= up.vld;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ok_s1   <= up.ok;
			box_s1  <= up.box;
			prod_s1 <= prod;
		end
		if (en_s2) begin
			ok_s2  <= ok_s1 && !reject;
			box_s2 <= box_s1;
		end
	end

	assign dn = '{vld: v_s2, ok: ok_s2, box: box_s2};

	`FBCT_ASSERT_NEXT(a_s2_holds, v_s2 && !dn_rdy, v_s2 && $stable(ok_s2), "stalled result moved")
	`FBCT_ASSERT_NEXT(a_veto_kept, en_s2 && v_s1 && !ok_s1, !ok_s2, "earlier rejection lost")
	`FBCT_ASSERT_SAME(a_empty_rdy, !v_s1, up_rdy, "empty first stage refused a request")

endmodule

// File: hw/rtl/frustum_box_containment_test.sv
// Pipeline: an input register, then six plane cells of two stages each.
// Throughput: one box per cycle while the result side does not stall.
// Backpressure from the result side stalls only the stages that hold data.
// Reset clears the matrix registers to zero and empties every stage.
// ----------------------------------------------------------------------------
// Frustum box containment test
// Tests axis-aligned boxes against the six clip planes of a view-projection
// matrix through a chain of plane cells.
// ----------------------------------------------------------------------------
`include "frustum_box_containment_test_macros.svh"

module frustum_box_containment_test #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [fbct_pkg::IDX_W-1:0]    wr_idx,
	input  logic [fbct_pkg::REG_W-1:0]    wr_data,
	fbct_box_if.sink                      box,
	fbct_res_if.source                    verdict
);

	logic [fbct_pkg::NUM_REGS-1:0][fbct_pkg::REG_W-1:0] mat_q;
	fbct_pkg::plane_t [fbct_pkg::NUM_PLANES-1:0]         pln;
	fbct_pkg::link_t                                     lnk [fbct_pkg::NUM_PLANES+1];
	logic                                                rdy [fbct_pkg::NUM_PLANES+1];
	logic                                                in_vld_q;
	fbct_pkg::box_t                                      in_box_q;
	logic                                                in_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q <= '0;
		end else if (wr_en && (wr_idx < fbct_pkg::IDX_W'(fbct_pkg::NUM_REGS))) begin
			mat_q[wr_idx[$clog2(fbct_pkg::NUM_REGS)-1:0]] <= wr_data;
		end
	end

	fbct_planes #(
		.FRAC_BITS(FRAC_BITS)
	) u_planes (
		.clk   (clk),
		.arst_n(arst_n),
		.mat   (mat_q),
		.pln   (pln)
	);

	assign in_en     = !in_vld_q || rdy[0];
	assign box.ready = in_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_q <= 1'b0;
		end else if (in_en) begin
			in_vld_q <= box.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_en) begin
			in_box_q.lo <= {box.box_min_z, box.box_min_y, box.box_min_x};
			in_box_q.hi <= {box.box_max_z, box.box_max_y, box.box_max_x};
		end
	end

	assign lnk[0] = '{vld: in_vld_q, ok: 1'b1, box: in_box_q};

	for (genvar p = 0; p < fbct_pkg::NUM_PLANES; p++) begin : g_cell
		fbct_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.pln   (pln[p]),
			.up    (lnk[p]),
			.up_rdy(rdy[p]),
			.dn    (lnk[p+1]),
			.dn_rdy(rdy[p+1])
		);
	end

	assign rdy[fbct_pkg::NUM_PLANES] = verdict.ready;
	assign verdict.valid             = lnk[fbct_pkg::NUM_PLANES].vld;
	assign verdict.box_inside        = lnk[fbct_pkg::NUM_PLANES].ok;

	`FBCT_ASSERT_NEXT(a_accept_lands, box.valid && box.ready, in_vld_q, "accepted box not held")
	`FBCT_ASSERT_NEXT(a_cfg_ignored, wr_en && (wr_idx >= fbct_pkg::IDX_W'(fbct_pkg::NUM_REGS)), $stable(mat_q), "write beyond the register list changed the matrix")
	`FBCT_ASSERT_SAME(a_empty_in_rdy, !in_vld_q, box.ready, "empty input register refused a request")

endmodule
